>>> src/keyboard_latch_with_paste_queue_core_defines.svh
// Assertion helpers shared by the keyboard latch RTL.
`ifndef KEYBOARD_LATCH_WITH_PASTE_QUEUE_CORE_DEFINES_SVH
`define KEYBOARD_LATCH_WITH_PASTE_QUEUE_CORE_DEFINES_SVH

// Check an invariant at every clock edge outside reset.
`define KLPQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a consequence in the same cycle as its condition.
`define KLPQ_ASSERT_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

>>> src/klpq_pkg.sv
package klpq_pkg;

   // Command codes
   localparam logic [2:0] CMD_KEY    = 3'd0;
   localparam logic [2:0] CMD_READ   = 3'd1;
   localparam logic [2:0] CMD_STROBE = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_APPEND = 3'd4;

   // Reset request codes
   localparam logic [1:0] RST_NONE       = 2'd0;
   localparam logic [1:0] RST_CTRL       = 2'd1;
   localparam logic [1:0] RST_APPLE_CTRL = 2'd2;

   // Scan codes of special keys
   localparam logic [7:0] SCAN_LEFT      = 8'h4B;
   localparam logic [7:0] SCAN_RIGHT     = 8'h4D;
   localparam logic [7:0] SCAN_CTRL_F2   = 8'h5F;
   localparam logic [7:0] SCAN_CTRL_F3   = 8'h60;

   // Character codes
   localparam logic [7:0] CHR_NUL        = 8'h00;
   localparam logic [7:0] CHR_BS         = 8'h08;
   localparam logic [7:0] CHR_NAK        = 8'h15;
   localparam logic [7:0] CHR_LF         = 8'h0A;
   localparam logic [7:0] CHR_CR         = 8'h0D;
   localparam logic [7:0] CHR_BACKTICK   = 8'h60;
   localparam logic [7:0] CHR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHR_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CHR_LBRACE     = 8'h7B;
   localparam logic [7:0] CASE_OFFSET    = 8'd32;

   // Keystroke translation outcome
   typedef struct packed {
      logic       put;
      logic [6:0] code;
      logic [1:0] rst;
      logic       dropped;
   } key_result_type;

   // Fold lower case letters to upper case
   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

>>> src/klpq_ram.sv
module klpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/klpq_keymap.sv
module klpq_keymap
   import klpq_pkg::*;
(
   input  logic [7:0]     ascii_code,
   input  logic [7:0]     scan_code,
   output key_result_type key_result
);

   logic [7:0] folded;

   assign folded = fold_upper(ascii_code);

   // Translate one keystroke
   always_comb begin
      key_result.put     = 1'b0;
      key_result.code    = folded[6:0];
      key_result.rst     = RST_NONE;
      key_result.dropped = 1'b0;
      if (ascii_code == CHR_NUL) begin
         if (scan_code == SCAN_CTRL_F2) begin
            key_result.rst = RST_CTRL;
         end else if (scan_code == SCAN_CTRL_F3) begin
            key_result.rst = RST_APPLE_CTRL;
         end else if (scan_code == SCAN_LEFT) begin
            key_result.put  = 1'b1;
            key_result.code = CHR_BS[6:0];
         end else if (scan_code == SCAN_RIGHT) begin
            key_result.put  = 1'b1;
            key_result.code = CHR_NAK[6:0];
         end else begin
            key_result.dropped = 1'b1;
         end
      end else if (ascii_code == CHR_BACKTICK || ascii_code >= CHR_LBRACE) begin
         key_result.dropped = 1'b1;
      end else begin
         key_result.put = 1'b1;
      end
   end

endmodule

>>> src/keyboard_latch_with_paste_queue_core.sv
// Channel  Dir  Word layout (low bit first)
// req      in   tuser: cmd[2:0]; tdata: ascii_code[7:0], scan_code[15:8], paste_byte[23:16]
// rsp      out  tdata: latch_byte[7:0], reset_request[9:8], key_dropped[10], queue_full[11],
//                      paste_active[12], zero[15:13]
//
// One command at a time, each accepted in idle and answered from emit.
// A latch read into a free latch with bytes queued passes through scan, which skips CR LF's LF:
// the paste store's single read port fetches one entry per cycle. Any other command goes to emit.
// Reset is synchronous and clears the queue and the latch; the store needs no clearing.
// A result waiting in the output register does not block accepting the next word; the
// result after it holds in emit with req_tready low until the register frees.
`include "keyboard_latch_with_paste_queue_core_defines.svh"

module keyboard_latch_with_paste_queue_core
   import klpq_pkg::*;
#(
   parameter int PASTE_DEPTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // ascii_code, scan_code, paste_byte
   input  logic [2:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // latch_byte, reset_request, key_dropped,
                                    // queue_full, paste_active
);

   localparam int AW = $clog2(PASTE_DEPTH);
   localparam int CW = $clog2(PASTE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  paste_count_ff, paste_count_in;
   logic [CW-1:0]  paste_index_ff, paste_index_in;
   logic [CW-1:0]  index_inc;
   logic           queue_live;
   logic           last_cr_ff, last_cr_in;
   logic           presented_ff, presented_in;
   logic [6:0]     latch_code_ff, latch_code_in;
   logic           latch_ready_ff, latch_ready_in;
   logic [1:0]     rst_req_ff, rst_req_in;
   logic           dropped_ff, dropped_in;
   logic           full_ff, full_in;
   logic           rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]    rsp_tdata_ff, rsp_tdata_in;
   logic           do_clear;
   logic           req_accept;
   logic           out_free;
   logic [2:0]     req_cmd;
   logic [7:0]     req_ascii;
   logic [7:0]     req_scan;
   logic [7:0]     req_paste;
   logic           wr_en;
   logic [AW-1:0]  rd_addr;
   logic [7:0]     rd_data;
   logic [7:0]     pres_code;
   key_result_type key_result;

   assign req_cmd   = req_tuser;
   assign req_ascii = req_tdata[7:0];
   assign req_scan  = req_tdata[15:8];
   assign req_paste = req_tdata[23:16];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;
   assign index_inc  = paste_index_ff + CW'(1);
   assign queue_live = (paste_index_ff < paste_count_ff);

   klpq_keymap u_keymap (
      .ascii_code (req_ascii),
      .scan_code  (req_scan),
      .key_result (key_result)
   );

   // Paste store; only one command runs at a time, so writes and reads never overlap
   klpq_ram #(
      .WIDTH (8),
      .DEPTH (PASTE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (paste_count_ff[AW-1:0]),
      .wr_data (req_paste),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Map a fetched entry to the latch code: LF becomes CR, then fold case
   assign pres_code = fold_upper((rd_data == CHR_LF) ? CHR_CR : rd_data);

   // Command sequencer
   always_comb begin
      state_in       = state_ff;
      paste_count_in = paste_count_ff;
      paste_index_in = paste_index_ff;
      last_cr_in     = last_cr_ff;
      presented_in   = presented_ff;
      latch_code_in  = latch_code_ff;
      latch_ready_in = latch_ready_ff;
      rst_req_in     = rst_req_ff;
      dropped_in     = dropped_ff;
      full_in        = full_ff;
      rsp_tvalid_in  = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in   = rsp_tdata_ff;
      rd_addr        = paste_index_ff[AW-1:0];
      wr_en          = 1'b0;
      do_clear       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rst_req_in = RST_NONE;
               dropped_in = 1'b0;
               full_in    = 1'b0;
               state_in   = ST_EMIT;
               case (req_cmd)
                  CMD_KEY: begin
                     rst_req_in = key_result.rst;
                     dropped_in = key_result.dropped;
                     if (key_result.put) begin
                        latch_code_in  = key_result.code;
                        latch_ready_in = 1'b1;
                        presented_in   = 1'b0;
                     end
                  end
                  CMD_READ: begin
                     // Fetch the next entry only into a free latch
                     if (!latch_ready_ff) begin
                        if (queue_live) begin
                           state_in = ST_SCAN;
                        end else begin
                           do_clear = 1'b1;
                        end
                     end
                  end
                  CMD_STROBE: begin
                     latch_ready_in = 1'b0;
                     if (presented_ff) begin
                        presented_in = 1'b0;
                        if (index_inc >= paste_count_ff) begin
                           do_clear = 1'b1;
                        end else begin
                           paste_index_in = index_inc;
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     do_clear = 1'b1;
                  end
                  CMD_APPEND: begin
                     if (paste_count_ff == CW'(PASTE_DEPTH)) begin
                        full_in = 1'b1;
                     end else begin
                        wr_en          = 1'b1;
                        paste_count_in = paste_count_ff + CW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_data == CHR_NUL) begin
               do_clear = 1'b1;
               state_in = ST_EMIT;
            end else if (rd_data == CHR_LF && last_cr_ff) begin
               // Skip the LF of a CR LF pair and fetch the next entry
               if (index_inc < paste_count_ff) begin
                  paste_index_in = index_inc;
                  rd_addr        = index_inc[AW-1:0];
               end else begin
                  do_clear = 1'b1;
                  state_in = ST_EMIT;
               end
            end else begin
               last_cr_in     = (pres_code == CHR_CR);
               latch_code_in  = pres_code[6:0];
               latch_ready_in = 1'b1;
               presented_in   = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Load the result word once the output register is free
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {3'b000, queue_live, full_ff,
                                dropped_ff, rst_req_ff, latch_ready_ff, latch_code_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Drop the whole queue
      if (do_clear) begin
         paste_count_in = '0;
         paste_index_in = '0;
         last_cr_in     = 1'b0;
         presented_in   = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         paste_count_ff <= '0;
         paste_index_ff <= '0;
         last_cr_ff     <= 1'b0;
         presented_ff   <= 1'b0;
         latch_code_ff  <= '0;
         latch_ready_ff <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         paste_count_ff <= paste_count_in;
         paste_index_ff <= paste_index_in;
         last_cr_ff     <= last_cr_in;
         presented_ff   <= presented_in;
         latch_code_ff  <= latch_code_in;
         latch_ready_ff <= latch_ready_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   // Result flags and output word
   always_ff @(posedge clock) begin
      rst_req_ff   <= rst_req_in;
      dropped_ff   <= dropped_in;
      full_ff      <= full_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `KLPQ_ASSERT_ALWAYS(a_index_within_count, paste_index_ff <= paste_count_ff, "index past count")
   `KLPQ_ASSERT_ALWAYS(a_count_within_depth, paste_count_ff <= CW'(PASTE_DEPTH), "count past depth")
   `KLPQ_ASSERT_IMPLY(a_presented_is_live, presented_ff, latch_ready_ff && queue_live, "stale byte")
   `KLPQ_ASSERT_IMPLY(a_scan_in_range, state_ff == ST_SCAN, queue_live, "fetch beyond the queue")
   `KLPQ_ASSERT_IMPLY(a_rsp_from_emit, $rose(rsp_tvalid_ff), $past(state_ff) == ST_EMIT, "early result")

endmodule

>>> tb/keyboard_latch_with_paste_queue_core_tb.sv
module keyboard_latch_with_paste_queue_core_tb
   import klpq_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PASTE_DEPTH  = 2048;
   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int MAX_PRINTED  = 40;

   // Command codes the block ignores
   localparam logic [2:0] CMD_UNUSED_5 = 3'd5;
   localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

   // Expected response word, one field per rsp_tdata field
   typedef struct packed {
      logic [7:0] latch;
      logic [1:0] chord;
      logic       dropped;
      logic       refused;
      logic       active;
   } latch_resp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // ascii_code, scan_code, paste_byte
   logic [2:0]  req_tuser;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // latch_byte, reset_request, key_dropped,
                             // queue_full, paste_active

   keyboard_latch_with_paste_queue_core #(
      .PASTE_DEPTH(PASTE_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // Mirror of the latch and paste queue
   logic [7:0] paste_mem [PASTE_DEPTH];
   int         fill_count;
   int         read_pos;
   bit         after_cr;
   bit         from_paste;
   bit         ready_flag;
   logic [6:0] held_code;

   latch_resp_type pending_resp[$];

   int words_sent;
   int resp_checked;
   int mismatches;
   int burst_left;
   int chars_pasted;
   int keys_dropped;
   int chords_seen;
   int appends_refused;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] c);
      if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
         return c - CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic void drop_paste();
      fill_count = 0;
      read_pos   = 0;
      after_cr   = 1'b0;
      from_paste = 1'b0;
   endfunction

   // Advance the latch mirror by one command and build its response
   function automatic latch_resp_type predict_latch(input logic [2:0] cmd,
                                                    input logic [7:0] ascii,
                                                    input logic [7:0] scan,
                                                    input logic [7:0] pb);
      latch_resp_type r;
      logic [7:0]     k;
      bit             put;
      bit             done;
      r   = '0;
      put = 1'b1;
      k   = '0;
      case (cmd)
         CMD_KEY: begin
            if (ascii == CHR_NUL) begin
               if (scan == SCAN_CTRL_F2) begin
                  r.chord = RST_CTRL;
                  put = 1'b0;
               end else if (scan == SCAN_CTRL_F3) begin
                  r.chord = RST_APPLE_CTRL;
                  put = 1'b0;
               end else if (scan == SCAN_LEFT) begin
                  k = CHR_BS;
               end else if (scan == SCAN_RIGHT) begin
                  k = CHR_NAK;
               end else begin
                  r.dropped = 1'b1;
                  put = 1'b0;
               end
            end else if (ascii == CHR_BACKTICK || ascii >= CHR_LBRACE) begin
               r.dropped = 1'b1;
               put = 1'b0;
            end else begin
               k = upcase(ascii);
            end
            if (put) begin
               held_code  = k[6:0];
               ready_flag = 1'b1;
               from_paste = 1'b0;
            end
            if (r.dropped) keys_dropped++;
            if (r.chord != RST_NONE) chords_seen++;
         end
         CMD_READ: begin
            // Present the next queued byte into a free latch
            if (!ready_flag) begin
               done = 1'b0;
               while (!done && read_pos < fill_count) begin
                  k = paste_mem[read_pos];
                  if (k == CHR_NUL) begin
                     drop_paste();
                     done = 1'b1;
                  end else if (k == CHR_LF && after_cr) begin
                     read_pos++;
                  end else begin
                     if (k == CHR_LF) k = CHR_CR;
                     k          = upcase(k);
                     after_cr   = (k == CHR_CR);
                     held_code  = k[6:0];
                     ready_flag = 1'b1;
                     from_paste = 1'b1;
                     chars_pasted++;
                     done = 1'b1;
                  end
               end
               if (!done) drop_paste();
            end
         end
         CMD_STROBE: begin
            ready_flag = 1'b0;
            if (from_paste) begin
               from_paste = 1'b0;
               read_pos++;
               if (read_pos >= fill_count) drop_paste();
            end
         end
         CMD_CLEAR: begin
            drop_paste();
         end
         CMD_APPEND: begin
            if (fill_count >= PASTE_DEPTH) begin
               r.refused = 1'b1;
               appends_refused++;
            end else begin
               paste_mem[fill_count] = pb;
               fill_count++;
            end
         end
         default: begin
         end
      endcase
      r.latch  = {ready_flag, held_code};
      r.active = (read_pos < fill_count);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("mismatch %0d at %0t: %s got 0x%0h want 0x%0h",
                  mismatches, $time, what, got, want);
      end
   endtask

   // Send one word, with burst and gap shaping on the request side
   task automatic send_word(input logic [2:0] cmd, input logic [7:0] ascii,
                            input logic [7:0] scan, input logic [7:0] pb);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      @(negedge clock);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pb, scan, ascii};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_resp.push_back(predict_latch(cmd, ascii, scan, pb));
      words_sent++;
   endtask

   // Hold off the sender until every response is back or the limit runs out
   task automatic wait_drain(input int limit);
      int waited;
      waited = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_resp.size() != 0 && waited < limit) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic send_key(input logic [7:0] ascii, input logic [7:0] scan);
      send_word(CMD_KEY, ascii, scan, any_byte());
   endtask

   task automatic send_simple(input logic [2:0] cmd);
      send_word(cmd, any_byte(), any_byte(), any_byte());
   endtask

   task automatic send_append(input logic [7:0] pb);
      send_word(CMD_APPEND, any_byte(), any_byte(), pb);
   endtask

   // Random key: special keys, lower case and the full ascii range
   task automatic send_random_key();
      int unsigned r;
      logic [7:0]  specials [4];
      specials = '{SCAN_LEFT, SCAN_RIGHT, SCAN_CTRL_F2, SCAN_CTRL_F3};
      r = $urandom_range(0, 99);
      if (r < 12) send_key(CHR_NUL, specials[$urandom_range(0, 3)]);
      else if (r < 18) send_key(CHR_NUL, any_byte());
      else if (r < 45) send_key(8'($urandom_range(CHR_LOWER_A, CHR_LOWER_Z)), any_byte());
      else send_key(any_byte(), any_byte());
   endtask

   // Paste byte biased toward line ends, NUL and lower case
   function automatic logic [7:0] paste_char(input bit lf_heavy);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (lf_heavy && r < 50) return CHR_LF;
      if (r < 18) return CHR_LF;
      if (r < 28) return CHR_CR;
      if (r < 31) return CHR_NUL;
      if (r < 60) return 8'($urandom_range(CHR_LOWER_A, CHR_LOWER_Z));
      return any_byte();
   endfunction

   task automatic test_keystrokes();
      send_simple(CMD_READ);
      send_key("a", any_byte());
      send_simple(CMD_READ);
      send_simple(CMD_STROBE);
      send_key(CHR_BACKTICK, any_byte());
      send_key(CHR_LBRACE, any_byte());
      send_key(8'hFF, 8'hFF);
      send_key(CHR_NUL, SCAN_LEFT);
      send_key(CHR_NUL, SCAN_RIGHT);
      send_key(CHR_NUL, SCAN_CTRL_F2);
      send_key(CHR_NUL, SCAN_CTRL_F3);
      send_key(CHR_NUL, 8'h00);
      send_simple(CMD_UNUSED_5);
      send_simple(CMD_UNUSED_7);
   endtask

   task automatic test_paste_rules();
      send_simple(CMD_STROBE);
      send_append("q");
      send_append(CHR_CR);
      send_append(CHR_LF);
      send_append(CHR_LF);
      send_append(CHR_NUL);
      send_simple(CMD_READ);
      // A typed key takes over the latch; its strobe leaves the queue put
      send_key("z", any_byte());
      send_simple(CMD_STROBE);
      send_simple(CMD_READ);
      send_simple(CMD_STROBE);
      send_simple(CMD_READ);
      send_simple(CMD_STROBE);
      // Both LFs after the CR are skipped, then NUL ends the paste
      send_simple(CMD_READ);
      send_simple(CMD_STROBE);
      // Strobe of the last queued byte empties the queue
      send_append("e");
      send_simple(CMD_READ);
      send_simple(CMD_STROBE);
   endtask

   task automatic test_random_traffic();
      int first;
      int n;
      int pick;
      bit lf_heavy;
      first = words_sent;
      while (words_sent - first < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            // Paste session: fill, then mostly read and strobe
            if ($urandom_range(0, 2) == 0) send_simple(CMD_CLEAR);
            n = $urandom_range(1, 24);
            lf_heavy = ($urandom_range(0, 5) == 0);
            repeat (n) send_append(paste_char(lf_heavy));
            repeat (2 * n + 4) begin
               pick = $urandom_range(0, 19);
               if (pick < 9) send_simple(CMD_READ);
               else if (pick < 17) send_simple(CMD_STROBE);
               else if (pick == 17) send_random_key();
               else if (pick == 18) send_append(paste_char(lf_heavy));
               else send_word(3'($urandom_range(0, 7)), any_byte(), any_byte(), any_byte());
            end
         end else if (pick < 7) begin
            // Typing session
            repeat ($urandom_range(1, 10)) begin
               send_random_key();
               if ($urandom_range(0, 1) == 0) send_simple(CMD_READ);
               if ($urandom_range(0, 9) < 6) send_simple(CMD_STROBE);
            end
         end else begin
            // Noise on every command code
            repeat ($urandom_range(1, 8)) begin
               send_word(3'($urandom_range(0, 7)), any_byte(), any_byte(), any_byte());
            end
         end
         if ($urandom_range(0, 49) == 0) wait_drain(DRAIN_LIMIT);
      end
   endtask

   task automatic test_full_store();
      send_simple(CMD_CLEAR);
      repeat (PASTE_DEPTH) send_append(paste_char(1'b0));
      send_append(any_byte());
      send_append(any_byte());
      repeat (6) begin
         send_simple(CMD_READ);
         send_simple(CMD_STROBE);
      end
      send_simple(CMD_CLEAR);
      send_simple(CMD_READ);
   endtask

   // Receiver ready follows a changing stall pattern
   initial begin : rsp_stall_pattern
      int          mode;
      int          left;
      logic [15:0] pattern;
      rsp_tready = 1'b0;
      left    = 0;
      mode    = 0;
      pattern = '1;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode    = $urandom_range(0, 3);
            left    = $urandom_range(8, 60);
            pattern = 16'($urandom);
         end
         left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: begin
               rsp_tready <= pattern[0];
               pattern = {pattern[0], pattern[15:1]};
            end
            2: rsp_tready <= ($urandom_range(0, 9) < 7);
            default: rsp_tready <= (left % 4 != 0);
         endcase
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin : rsp_check
      latch_resp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_resp.size() == 0) begin
            report_mismatch("response with none expected", rsp_tdata, 0);
         end else begin
            want = pending_resp.pop_front();
            resp_checked++;
            if (rsp_tdata[7:0] != want.latch)
               report_mismatch("latch_byte", rsp_tdata[7:0], want.latch);
            if (rsp_tdata[9:8] != want.chord)
               report_mismatch("reset_request", rsp_tdata[9:8], want.chord);
            if (rsp_tdata[10] != want.dropped)
               report_mismatch("key_dropped", rsp_tdata[10], want.dropped);
            if (rsp_tdata[11] != want.refused)
               report_mismatch("queue_full", rsp_tdata[11], want.refused);
            if (rsp_tdata[12] != want.active)
               report_mismatch("paste_active", rsp_tdata[12], want.active);
            if (rsp_tdata[15:13] != 3'b0)
               report_mismatch("pad bits", rsp_tdata[15:13], 0);
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      burst_left = 0;
      drop_paste();
      ready_flag = 1'b0;
      held_code  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_keystrokes();
      wait_drain(DRAIN_LIMIT);
      test_paste_rules();
      wait_drain(DRAIN_LIMIT);
      test_random_traffic();
      wait_drain(DRAIN_LIMIT);
      test_full_store();
      wait_drain(DRAIN_LIMIT);
      repeat (20) @(negedge clock);

      while (pending_resp.size() != 0) begin
         void'(pending_resp.pop_front());
         report_mismatch("response never arrived", 0, 0);
      end

      $display("covered %0d commands, %0d responses compared, %0d mismatches",
               words_sent, resp_checked, mismatches);
      $display("pasted chars %0d, dropped keys %0d, reset chords %0d, refused appends %0d",
               chars_pasted, keys_dropped, chords_seen, appends_refused);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
